// ----- hdl/sfd_pkg.sv -----
// shared types and constants of the serial frame decoder
package sfd_pkg;

  localparam logic [7:0] START_BYTE = 8'hFE;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_FUNC_HI = 7'b0000010,
    PH_FUNC_LO = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_LEN_LO  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_LOAD = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [15:0] function_code;
    logic [6:0]  length;
    logic        bank;
  } desc_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [5:0] addr;
    logic [7:0] data;
  } wr_port_t;

  typedef struct packed {
    logic en;
    logic bank;
  } free_t;

endpackage

// ----- hdl/sfd_if.sv -----
// valid/ready channel interfaces for received bytes and decoded results
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] function_code;
  logic [6:0]  payload_length;
  logic [5:0]  byte_index;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (
    output valid, output function_code, output payload_length,
    output byte_index, output payload_byte, output last, input ready
  );
  modport sink (
    input valid, input function_code, input payload_length,
    input byte_index, input payload_byte, input last, output ready
  );
endinterface

// ----- hdl/serial_frame_decoder_xor_check.sv -----
// top level of the serial frame decoder with xor checksum
//
// rx_i carries one received byte per transaction. The parser hunts for the
// start byte 0xFE, takes a 16-bit function code and a 16-bit length (msb
// first), stores up to MAX_PAYLOAD payload bytes and checks one xor byte.
// Lengths above MAX_PAYLOAD send it back to hunting; bad frames vanish.
// res_o carries one transaction per payload byte of a good frame, or one
// for an empty payload, the final one flagged by last.
// Input: one byte per cycle. The payload store has two banks, so the
// replay of one frame overlaps the reception of the next; rx_i.ready drops
// only in the payload or checksum phase while the target bank still holds
// a frame that is queued or being replayed.
// After the checksum byte is taken, the descriptor passes the queue, the
// idle state, the registered store read and the output register load;
// an empty payload skips the store read. Each result needs a registered
// store read followed by the output register load, one result at a time.
// A stalled receiver holds the output register; the replay waits and the
// parser keeps going until it needs a busy bank.
// Reset clears the parser to hunting, the queue and the replay engine; the
// store contents are not cleared.
module serial_frame_decoder_xor_check #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfd_byte_if.sink     rx_i,
  sfd_result_if.source res_o
);
  import sfd_pkg::*;

  wr_port_t wr;
  desc_t    push_desc, head;
  free_t    free;
  logic     push, pop, empty;

  sfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .wr_o        (wr),
    .push_o      (push),
    .push_desc_o (push_desc),
    .free_i      (free)
  );

  sfd_desc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  sfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .free_o  (free),
    .res_o   (res_o)
  );

endmodule

// ----- hdl/sfd_front.sv -----
// frame parser: start byte hunt, header capture, payload store writes, checksum
module sfd_front #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfd_byte_if.sink         rx_i,
  output sfd_pkg::wr_port_t wr_o,
  output logic             push_o,
  output sfd_pkg::desc_t   push_desc_o,
  input  sfd_pkg::free_t   free_i
);
  import sfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] func_q, func_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [6:0]  len_q, len_d;
  logic [5:0]  idx_q, idx_d;
  logic [7:0]  xor_q, xor_d;
  logic        bank_q, bank_d;
  logic [1:0]  busy_q, busy_d;
  logic [1:0]  set_mask, free_mask;
  logic [15:0] len_full;
  logic        accept;
  logic [7:0]  b;

  assign b        = rx_i.rx_byte;
  assign accept   = rx_i.valid && rx_i.ready;
  assign len_full = {len_hi_q, b};

  always_comb begin
    if (phase_q == PH_PAYLOAD || phase_q == PH_CHECK) begin
      rx_i.ready = !busy_q[bank_q];
    end else begin
      rx_i.ready = 1'b1;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    func_d      = func_q;
    len_hi_d    = len_hi_q;
    len_d       = len_q;
    idx_d       = idx_q;
    xor_d       = xor_q;
    bank_d      = bank_q;
    set_mask    = 2'b00;
    push_o      = 1'b0;
    wr_o.en     = 1'b0;
    wr_o.bank   = bank_q;
    wr_o.addr   = idx_q;
    wr_o.data   = b;
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            xor_d   = START_BYTE;
            phase_d = PH_FUNC_HI;
          end
        end
        PH_FUNC_HI: begin
          func_d  = {b, 8'h00};
          xor_d   = xor_q ^ b;
          phase_d = PH_FUNC_LO;
        end
        PH_FUNC_LO: begin
          func_d  = {func_q[15:8], b};
          xor_d   = xor_q ^ b;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_d = b;
          xor_d    = xor_q ^ b;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          xor_d = xor_q ^ b;
          idx_d = 6'd0;
          len_d = len_full[6:0];
          if (len_full > 16'(MAX_PAYLOAD)) begin
            phase_d = PH_HUNT;
          end else if (len_full == 16'd0) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          wr_o.en = 1'b1;
          xor_d   = xor_q ^ b;
          if ({1'b0, idx_q} + 7'd1 == len_q) begin
            idx_d   = 6'd0;
            phase_d = PH_CHECK;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
        PH_CHECK: begin
          if (b == xor_q) begin
            push_o   = 1'b1;
            set_mask = bank_q ? 2'b10 : 2'b01;
            bank_d   = ~bank_q;
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    free_mask = 2'b00;
    if (free_i.en) begin
      free_mask = free_i.bank ? 2'b10 : 2'b01;
    end
    busy_d = (busy_q & ~free_mask) | set_mask;
  end

  assign push_desc_o.function_code = func_q;
  assign push_desc_o.length        = len_q;
  assign push_desc_o.bank          = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      func_q   <= 16'd0;
      len_hi_q <= 8'd0;
      len_q    <= 7'd0;
      idx_q    <= 6'd0;
      xor_q    <= 8'd0;
      bank_q   <= 1'b0;
      busy_q   <= 2'b00;
    end else begin
      phase_q  <= phase_d;
      func_q   <= func_d;
      len_hi_q <= len_hi_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      xor_q    <= xor_d;
      bank_q   <= bank_d;
      busy_q   <= busy_d;
    end
  end

  a_stall_only_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (phase_q == PH_PAYLOAD || phase_q == PH_CHECK))
    else $error("front stalled outside payload or check phase");

  a_claim_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !busy_q[bank_q])
    else $error("payload written into a bank still being replayed");

endmodule

// ----- hdl/sfd_desc_fifo.sv -----
// two-entry queue of validated frame descriptors between parser and replay
module sfd_desc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfd_pkg::desc_t push_desc_i,
  input  logic           pop_i,
  output sfd_pkg::desc_t head_o,
  output logic           empty_o
);
  import sfd_pkg::*;

  desc_t      slot_q [FIFO_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign head_o  = slot_q[rd_q];
  assign empty_o = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'(FIFO_DEPTH))
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("descriptor queue underflow");

endmodule

// ----- hdl/sfd_back.sv -----
// replay engine: double-banked payload store and result output register
module sfd_back #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfd_pkg::wr_port_t wr_i,
  input  sfd_pkg::desc_t    head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output sfd_pkg::free_t    free_o,
  sfd_result_if.source      res_o
);
  import sfd_pkg::*;

  localparam int unsigned DEPTH  = 2 * MAX_PAYLOAD;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rd_q;
  back_state_e st_q, st_d;
  desc_t       act_q;
  logic [5:0]  idx_q, idx_d;
  logic        ov_q, ov_d;
  logic [15:0] ofunc_q;
  logic [6:0]  olen_q;
  logic [5:0]  oidx_q;
  logic [7:0]  obyte_q;
  logic        olast_q;
  logic        load, is_empty, is_last;

  function automatic logic [ADDR_W-1:0] addr_of(input logic bank, input logic [5:0] idx);
    return bank ? ADDR_W'(32'(MAX_PAYLOAD) + 32'(idx)) : ADDR_W'(idx);
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[addr_of(wr_i.bank, wr_i.addr)] <= wr_i.data;
    end
    if (st_q == B_READ) begin
      rd_q <= mem[addr_of(act_q.bank, idx_q)];
    end
  end

  assign is_empty    = (act_q.length == 7'd0);
  assign is_last     = is_empty || ({1'b0, idx_q} + 7'd1 == act_q.length);
  assign load        = (st_q == B_LOAD) && (!ov_q || res_o.ready);
  assign pop_o       = (st_q == B_IDLE) && !empty_i;
  assign free_o.en   = load && is_last;
  assign free_o.bank = act_q.bank;

  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    unique case (st_q)
      B_IDLE: begin
        if (!empty_i) begin
          idx_d = 6'd0;
          st_d  = (head_i.length == 7'd0) ? B_LOAD : B_READ;
        end
      end
      B_READ: begin
        st_d = B_LOAD;
      end
      B_LOAD: begin
        if (load) begin
          if (is_last) begin
            st_d = B_IDLE;
          end else begin
            idx_d = idx_q + 6'd1;
            st_d  = B_READ;
          end
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (res_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= B_IDLE;
      idx_q <= 6'd0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      act_q <= head_i;
    end
    if (load) begin
      ofunc_q <= act_q.function_code;
      olen_q  <= act_q.length;
      oidx_q  <= is_empty ? 6'd0 : idx_q;
      obyte_q <= is_empty ? 8'd0 : rd_q;
      olast_q <= is_last;
    end
  end

  assign res_o.valid          = ov_q;
  assign res_o.function_code  = ofunc_q;
  assign res_o.payload_length = olen_q;
  assign res_o.byte_index     = oidx_q;
  assign res_o.payload_byte   = obyte_q;
  assign res_o.last           = olast_q;

  a_load_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> res_o.valid)
    else $error("loaded result not presented");

  a_empty_frame_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.payload_length == 7'd0) |->
      (res_o.last && res_o.byte_index == 6'd0 && res_o.payload_byte == 8'd0))
    else $error("malformed empty-frame result");

endmodule

// ----- verif/serial_frame_decoder_xor_check_tb.sv -----
// testbench for the serial frame decoder: directed and random frames against a byte-level predictor
`timescale 1ns / 1ps

module serial_frame_decoder_xor_check_tb;
  import sfd_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned RANDOM_BYTES = 80;

  typedef enum {FLAW_NONE, FLAW_CHECKSUM, FLAW_LENGTH} frame_flaw_e;
  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    logic [15:0] function_code;
    logic [6:0]  payload_length;
    logic [5:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        last;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sfd_byte_if   rx_ch ();
  sfd_result_if res_ch ();

  serial_frame_decoder_xor_check #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_ch),
    .res_o (res_ch)
  );

  always #5 clk_i = ~clk_i;

  frame_result_t pending_results [$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  bit            hold_request = 1'b0;

  phase_e      frame_phase = PH_HUNT;
  logic [15:0] frame_func = '0;
  logic [15:0] frame_len = '0;
  logic [6:0]  frame_fill = '0;
  logic [7:0]  frame_sum = '0;
  logic [7:0]  frame_store [MAX_PAYLOAD];

  function automatic void decode_rx_byte(input logic [7:0] b);
    frame_result_t r;
    int unsigned   n;
    case (frame_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          frame_sum = START_BYTE;
          frame_phase = PH_FUNC_HI;
        end
      end
      PH_FUNC_HI: begin
        frame_func = {b, 8'h00};
        frame_sum ^= b;
        frame_phase = PH_FUNC_LO;
      end
      PH_FUNC_LO: begin
        frame_func[7:0] = b;
        frame_sum ^= b;
        frame_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len = {b, 8'h00};
        frame_sum ^= b;
        frame_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len[7:0] = b;
        frame_sum ^= b;
        frame_fill = '0;
        if (frame_len > MAX_PAYLOAD) frame_phase = PH_HUNT;
        else if (frame_len == 0) frame_phase = PH_CHECK;
        else frame_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        frame_store[frame_fill[5:0]] = b;
        frame_sum ^= b;
        frame_fill = frame_fill + 7'd1;
        if (frame_fill >= frame_len) begin
          frame_fill = '0;
          frame_phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (b == frame_sum) begin
          n = frame_len;
          if (n == 0) begin
            r = '{function_code: frame_func, payload_length: '0, byte_index: '0,
                  payload_byte: '0, last: 1'b1};
            pending_results.push_back(r);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              r.function_code = frame_func;
              r.payload_length = 7'(n);
              r.byte_index = 6'(i);
              r.payload_byte = frame_store[i];
              r.last = (i + 1 == n);
              pending_results.push_back(r);
            end
          end
        end
        frame_phase = PH_HUNT;
      end
      default: frame_phase = PH_HUNT;
    endcase
  endfunction

  function automatic void report_field(input string name, input logic [15:0] want,
                                       input logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    frame_result_t seen;
    frame_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      seen = {res_ch.function_code, res_ch.payload_length, res_ch.byte_index,
              res_ch.payload_byte, res_ch.last};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %h", $time, seen);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("function_code", want.function_code, seen.function_code);
        report_field("payload_length", 16'(want.payload_length), 16'(seen.payload_length));
        report_field("byte_index", 16'(want.byte_index), 16'(seen.byte_index));
        report_field("payload_byte", 16'(want.payload_byte), 16'(seen.payload_byte));
        report_field("last", 16'(want.last), 16'(seen.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time, pending_results.size());
      $display("serial_frame_decoder_xor_check verification failed");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    decode_rx_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [15:0] func, input logic [15:0] len,
                            input byte_q_t payload, input frame_flaw_e flaw);
    logic [7:0] sum;
    byte_q_t    frame;
    frame = {START_BYTE, func[15:8], func[7:0], len[15:8], len[7:0]};
    foreach (payload[i]) frame.push_back(payload[i]);
    sum = 8'h00;
    foreach (frame[i]) sum ^= frame[i];
    if (flaw == FLAW_CHECKSUM) sum ^= 8'($urandom_range(1, 255));
    if (flaw != FLAW_LENGTH) frame.push_back(sum);
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task automatic drain_results;
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_empty_frame;
    byte_q_t p;
    p = {};
    send_frame(16'hFFFF, 16'd0, p, FLAW_NONE);
  endtask

  task automatic test_payload_extremes;
    byte_q_t p;
    p = {8'h00, 8'hFF, START_BYTE};
    send_frame(16'h0000, 16'd3, p, FLAW_NONE);
  endtask

  task automatic test_bad_checksum;
    byte_q_t p;
    p = {};
    send_frame(16'h1234, 16'd0, p, FLAW_CHECKSUM);
  endtask

  task automatic test_length_too_long;
    byte_q_t p;
    p = {};
    send_frame(16'hA55A, 16'(MAX_PAYLOAD + 1), p, FLAW_LENGTH);
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [15:0] func;
    byte_q_t     p;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      pick = $urandom_range(99);
      func = 16'($urandom);
      p = {};
      if (pick < 88) begin
        len = $urandom_range(99);
        len = (len < 10) ? 0 : (len < 80) ? $urandom_range(1, 8) :
              (len < 95) ? $urandom_range(9, MAX_PAYLOAD - 1) : MAX_PAYLOAD;
        repeat (len) p.push_back(8'($urandom));
        send_frame(func, 16'(len), p, (pick < 75) ? FLAW_NONE : FLAW_CHECKSUM);
      end else if (pick < 94) begin
        repeat ($urandom_range(0, 4)) p.push_back(8'($urandom));
        send_frame(func, 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF)), p, FLAW_LENGTH);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_backpressure;
    byte_q_t p;
    drain_results();
    hold_request = 1'b1;
    repeat (3) begin
      p = {};
      repeat (40) p.push_back(8'($urandom));
      send_frame(16'($urandom), 16'd40, p, FLAW_NONE);
    end
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 81;
    test_empty_frame();
    test_payload_extremes();
    test_bad_checksum();
    test_length_too_long();
    test_random_traffic(RANDOM_BYTES);
    drain_results();

    send_idle_pct = 81;
    recv_idle_pct = 17;
    test_random_traffic(RANDOM_BYTES);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_BYTES);
    test_backpressure();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("serial_frame_decoder_xor_check verification clean");
    end else begin
      $display("serial_frame_decoder_xor_check verification failed");
    end
    $finish;
  end

endmodule
